FILE: src/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned TickW = 16;
  localparam logic [TickW-1:0] PhaseTicksReset = 16'd167;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_STOP     = 3'd1;
  localparam logic [2:0] KIND_WRITE    = 3'd2;
  localparam logic [2:0] KIND_READ     = 3'd3;
  localparam logic [2:0] KIND_SEND_ACK = 3'd4;
  localparam logic [2:0] KIND_RECV_ACK = 3'd5;

  localparam logic [AddrW-1:0] ENTRY_START    = 5'd0;
  localparam logic [AddrW-1:0] ENTRY_STOP     = 5'd4;
  localparam logic [AddrW-1:0] ENTRY_WRITE    = 5'd7;
  localparam logic [AddrW-1:0] ENTRY_READ     = 5'd10;
  localparam logic [AddrW-1:0] ENTRY_READ_BIT = 5'd11;
  localparam logic [AddrW-1:0] ENTRY_SEND_ACK = 5'd13;
  localparam logic [AddrW-1:0] ENTRY_RECV_ACK = 5'd16;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic [7:0] line_bits;
    logic       line_ack;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       ack_bit;
    logic       last;
  } phase_item_t;

  typedef enum logic [1:0] {
    SCL_KEEP,
    SCL_LO,
    SCL_HI
  } scl_op_t;

  typedef enum logic [2:0] {
    SDA_KEEP,
    SDA_LO,
    SDA_HI,
    SDA_TX,
    SDA_ACK
  } sda_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_END
  } seq_op_t;

  typedef struct packed {
    scl_op_t          scl;
    sda_op_t          sda;
    logic             shift_tx;
    logic             sample_bit;
    logic             sample_ack;
    logic             show_byte;
    logic             show_ack;
    seq_op_t          seq;
    logic [AddrW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    logic   fin;
    ucode_t cw;
  } dp_ctrl_t;

  function automatic ucode_t uc(scl_op_t scl, sda_op_t sda, logic shift_tx,
                                logic sample_bit, logic sample_ack,
                                logic show_byte, logic show_ack,
                                seq_op_t seq, logic [AddrW-1:0] target);
    ucode_t w;
    w.scl        = scl;
    w.sda        = sda;
    w.shift_tx   = shift_tx;
    w.sample_bit = sample_bit;
    w.sample_ack = sample_ack;
    w.show_byte  = show_byte;
    w.show_ack   = show_ack;
    w.seq        = seq;
    w.target     = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [AddrW-1:0] addr);
    ucode_t w;
    unique case (addr)
      5'd0:  w = uc(SCL_KEEP, SDA_HI,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd1:  w = uc(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd2:  w = uc(SCL_KEEP, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd3:  w = uc(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_END,  '0);
      5'd4:  w = uc(SCL_KEEP, SDA_LO,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd5:  w = uc(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd6:  w = uc(SCL_KEEP, SDA_HI,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_END,  '0);
      5'd7:  w = uc(SCL_KEEP, SDA_TX,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd8:  w = uc(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd9:  w = uc(SCL_LO,   SDA_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_LOOP,
                    ENTRY_WRITE);
      5'd10: w = uc(SCL_KEEP, SDA_HI,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd11: w = uc(SCL_HI,   SDA_KEEP, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd12: w = uc(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, SEQ_LOOP,
                    ENTRY_READ_BIT);
      5'd13: w = uc(SCL_KEEP, SDA_ACK,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd14: w = uc(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd15: w = uc(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_END,  '0);
      5'd16: w = uc(SCL_KEEP, SDA_HI,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd17: w = uc(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, SEQ_NEXT, '0);
      5'd18: w = uc(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, SEQ_END,  '0);
      default: w = uc(SCL_KEEP, SDA_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEQ_END, '0);
    endcase
    return w;
  endfunction

  function automatic logic [AddrW-1:0] kind_entry(logic [2:0] kind);
    logic [AddrW-1:0] a;
    unique case (kind)
      KIND_START:    a = ENTRY_START;
      KIND_STOP:     a = ENTRY_STOP;
      KIND_WRITE:    a = ENTRY_WRITE;
      KIND_READ:     a = ENTRY_READ;
      KIND_SEND_ACK: a = ENTRY_SEND_ACK;
      KIND_RECV_ACK: a = ENTRY_RECV_ACK;
      default:       a = ENTRY_START;
    endcase
    return a;
  endfunction

  function automatic logic kind_known(logic [2:0] kind);
    return (kind == KIND_START) || (kind == KIND_STOP) || (kind == KIND_WRITE) ||
           (kind == KIND_READ) || (kind == KIND_SEND_ACK) || (kind == KIND_RECV_ACK);
  endfunction

endpackage

FILE: src/i2cm_seq.sv
module i2cm_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic [2:0]                   cmd_kind,
  input  logic                         out_stall,
  input  logic                         cfg_wr_en,
  input  logic [i2cm_pkg::TickW-1:0]   cfg_wr_data,
  output logic                         busy,
  output i2cm_pkg::dp_ctrl_t           ctrl
);
  import i2cm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_HOLD
  } state_t;

  state_t           state;
  logic [AddrW-1:0] step;
  logic [2:0]       bit_cnt;
  logic [TickW-1:0] timer;
  logic [TickW-1:0] phase_ticks;
  ucode_t           cw;
  logic             fin;

  assign cw   = ucode_rom(step);
  assign fin  = (cw.seq == SEQ_END) || ((cw.seq == SEQ_LOOP) && (bit_cnt == LAST_BIT));
  assign busy = (state != S_IDLE);

  assign ctrl.load = (state == S_IDLE) && cmd_valid;
  assign ctrl.exec = (state == S_EXEC);
  assign ctrl.fin  = fin;
  assign ctrl.cw   = cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      bit_cnt     <= '0;
      timer       <= '0;
      phase_ticks <= PhaseTicksReset;
    end else begin
      if (cfg_wr_en) begin
        phase_ticks <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && kind_known(cmd_kind)) begin
            step    <= kind_entry(cmd_kind);
            bit_cnt <= '0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          timer <= phase_ticks;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (timer <= 16'd1) begin
            if (fin) begin
              state <= S_IDLE;
            end else if (cw.seq == SEQ_LOOP) begin
              step    <= cw.target;
              bit_cnt <= bit_cnt + 3'd1;
              state   <= S_EXEC;
            end else begin
              step  <= step + 5'd1;
              state <= S_EXEC;
            end
          end else begin
            timer <= timer - 16'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/i2cm_dp.sv
module i2cm_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  i2cm_pkg::dp_ctrl_t    ctrl,
  input  i2cm_pkg::cmd_item_t   cmd,
  input  logic                  out_stall,
  output logic                  out_valid,
  output i2cm_pkg::phase_item_t out_item
);
  import i2cm_pkg::*;

  logic       scl_drive;
  logic       sda_drive;
  logic       scl_drive_next;
  logic       sda_drive_next;
  logic [7:0] tx;
  logic [7:0] lb;
  logic [7:0] rx;
  logic       ack_send;
  logic       ack_line;
  logic       ack_seen;

  always_comb begin
    unique case (ctrl.cw.scl)
      SCL_LO:  scl_drive_next = 1'b0;
      SCL_HI:  scl_drive_next = 1'b1;
      default: scl_drive_next = scl_drive;
    endcase
    unique case (ctrl.cw.sda)
      SDA_LO:  sda_drive_next = 1'b0;
      SDA_HI:  sda_drive_next = 1'b1;
      SDA_TX:  sda_drive_next = tx[7];
      SDA_ACK: sda_drive_next = ack_send;
      default: sda_drive_next = sda_drive;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_drive <= 1'b1;
      sda_drive <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        scl_drive <= scl_drive_next;
        sda_drive <= sda_drive_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tx       <= cmd.write_byte;
      lb       <= cmd.line_bits;
      ack_send <= cmd.ack_to_send;
      ack_line <= cmd.line_ack;
      rx       <= '0;
    end else if (ctrl.exec) begin
      if (ctrl.cw.shift_tx) begin
        tx <= {tx[6:0], 1'b0};
      end
      if (ctrl.cw.sample_bit) begin
        rx <= {rx[6:0], lb[7]};
        lb <= {lb[6:0], 1'b0};
      end
      if (ctrl.cw.sample_ack) begin
        ack_seen <= ack_line;
      end
    end
    if (ctrl.exec) begin
      out_item.scl_level <= scl_drive_next;
      out_item.sda_level <= sda_drive_next;
      out_item.read_byte <= (ctrl.fin && ctrl.cw.show_byte) ? rx : 8'd0;
      out_item.ack_bit   <= ctrl.fin && ctrl.cw.show_ack && ack_seen;
      out_item.last      <= ctrl.fin;
    end
  end

endmodule

FILE: src/i2c_master_bit_engine.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_item    (one bus command)
// out       output     out_valid / out_stall  out_item   (one pin phase)
// cfg       input      cfg_wr_en              cfg_wr_data (phase_ticks)
//
// Each pin phase is one microcode step; its length is set by the phase timer,
// which is loaded from phase_ticks, and it grows while out_stall is held.
// A command runs its phase count (3 to 24) of phases after its accept cycle.
// in_stall is high from acceptance until the hold of the final phase ends.
// Unknown commands are dropped in the accept cycle. Reset is synchronous and
// leaves both lines released high with phase_ticks at 167.
module i2c_master_bit_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cm_pkg::cmd_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cm_pkg::phase_item_t out_item,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data
);
  import i2cm_pkg::*;

  dp_ctrl_t ctrl;
  logic     busy;

  assign in_stall = busy;

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (in_valid),
    .cmd_kind    (in_item.kind),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (busy),
    .ctrl        (ctrl)
  );

  i2cm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cmd       (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
